// ----- design/csu_pkg.sv -----
// Shared types, widths and helpers for the cosine similarity unit.
`default_nettype none
package csu_pkg;

	localparam int ELEM_W     = 16;
	localparam int PROD_W     = 2 * ELEM_W;
	localparam int SUM_W      = 48;
	localparam int ROOT_IN_W  = 64;
	localparam int ROOT_W     = 32;
	localparam int DEN_W      = 2 * ROOT_W;
	localparam int ROOT_SHIFT = ROOT_IN_W - SUM_W;
	localparam int QUOT_W     = 31;
	localparam int DIV_STEPS  = QUOT_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int SIM_W      = 16;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic signed [SIM_W-1:0] SIM_MAX = {1'b0, {(SIM_W-1){1'b1}}};
	localparam logic signed [SIM_W-1:0] SIM_MIN = {1'b1, {(SIM_W-1){1'b0}}};

	typedef struct packed {
		logic signed [SUM_W-1:0] dot;
		logic signed [SUM_W-1:0] norm_a;
		logic signed [SUM_W-1:0] norm_b;
	} csu_sums_t;

	// Saturating add of a product into a running sum.
	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0]  acc,
		input logic signed [PROD_W-1:0] p
	);
		logic signed [SUM_W:0] s;
		s = {acc[SUM_W-1], acc} + {{(SUM_W + 1 - PROD_W){p[PROD_W-1]}}, p};
		if (s[SUM_W] != s[SUM_W-1]) begin
			return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end
		return s[SUM_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- design/csu_front.sv -----
// Front end: per-pair products and the three saturating running sums.
`default_nettype none
module csu_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [csu_pkg::ELEM_W-1:0]  a_elem,
	input  wire logic signed [csu_pkg::ELEM_W-1:0]  b_elem,
	input  wire logic                               last,
	output logic                                    push_valid,
	input  wire logic                               push_ready,
	output csu_pkg::csu_sums_t                      push_data
);

	logic                                 valid_s1;
	logic                                 last_s1;
	logic signed [csu_pkg::PROD_W-1:0]    dot_p_s1;
	logic signed [csu_pkg::PROD_W-1:0]    na_p_s1;
	logic signed [csu_pkg::PROD_W-1:0]    nb_p_s1;
	logic signed [csu_pkg::SUM_W-1:0]     dot_q;
	logic signed [csu_pkg::SUM_W-1:0]     na_q;
	logic signed [csu_pkg::SUM_W-1:0]     nb_q;
	logic                                 advance;

	// Stage 1 stalls only when it holds a final pair and the queue is full.
	assign advance    = !(valid_s1 && last_s1) || push_ready;
	assign in_ready   = advance;
	assign push_valid = valid_s1 && last_s1;

	always_comb begin
		push_data.dot    = csu_pkg::sat_add(dot_q, dot_p_s1);
		push_data.norm_a = csu_pkg::sat_add(na_q, na_p_s1);
		push_data.norm_b = csu_pkg::sat_add(nb_q, nb_p_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			last_s1  <= last;
			dot_p_s1 <= a_elem * b_elem;
			na_p_s1  <= a_elem * a_elem;
			nb_p_s1  <= b_elem * b_elem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			na_q  <= '0;
			nb_q  <= '0;
		end else if (valid_s1 && advance) begin
			if (last_s1) begin
				dot_q <= '0;
				na_q  <= '0;
				nb_q  <= '0;
			end else begin
				dot_q <= push_data.dot;
				na_q  <= push_data.norm_a;
				nb_q  <= push_data.norm_b;
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/csu_fifo.sv -----
// Short queue of finished sum triples between front and back end.
`default_nettype none
module csu_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push_valid,
	output logic                    push_ready,
	input  wire csu_pkg::csu_sums_t push_data,
	output logic                    pop_valid,
	input  wire logic               pop_ready,
	output csu_pkg::csu_sums_t      pop_data
);

	csu_pkg::csu_sums_t                 mem_q [csu_pkg::FIFO_DEPTH];
	logic [csu_pkg::FIFO_PTR_W-1:0]     wr_ptr_q;
	logic [csu_pkg::FIFO_PTR_W-1:0]     rd_ptr_q;
	logic [csu_pkg::FIFO_CNT_W-1:0]     count_q;
	logic                               do_push;
	logic                               do_pop;

	assign push_ready = (count_q != csu_pkg::FIFO_CNT_W'(csu_pkg::FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/csu_back.sv -----
// Back end: two bit-serial square roots, one multiply, restoring divide, output register.
`default_nettype none
module csu_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               fifo_valid,
	output logic                                    fifo_pop,
	input  wire csu_pkg::csu_sums_t                 fifo_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [csu_pkg::SIM_W-1:0]        similarity,
	output logic                                    zero_norm
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQRT = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_SIGN = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	localparam logic [csu_pkg::ROOT_IN_W-1:0] BIT_INIT =
		{2'b01, {(csu_pkg::ROOT_IN_W-2){1'b0}}};

	logic [2:0]                             state_q;
	logic signed [csu_pkg::SUM_W-1:0]       dot_q;
	logic [csu_pkg::ROOT_IN_W-1:0]          xa_q, ra_q, xb_q, rb_q, bit_q;
	logic [csu_pkg::DEN_W-1:0]              den_q;
	logic [csu_pkg::ROOT_IN_W-1:0]          r_q;
	logic [csu_pkg::QUOT_W-1:0]             quot_q;
	logic [csu_pkg::DIV_CNT_W-1:0]          cnt_q;
	logic                                   neg_q;
	logic signed [csu_pkg::SIM_W-1:0]       sim_q;
	logic                                   zero_q;
	logic                                   out_valid_q;
	logic signed [csu_pkg::SIM_W-1:0]       out_sim_q;
	logic                                   out_zero_q;

	logic [csu_pkg::ROOT_IN_W-1:0]          xa_n, ra_n, xb_n, rb_n;
	logic [csu_pkg::ROOT_IN_W-1:0]          ta, tb;
	logic [csu_pkg::SUM_W-1:0]              mag;
	logic [csu_pkg::ROOT_IN_W-1:0]          mag_sh;
	logic [csu_pkg::ROOT_IN_W-1:0]          r_sh;
	logic                                   div_ge;
	logic                                   out_load;

	assign fifo_pop   = (state_q == ST_IDLE) && fifo_valid;
	assign out_valid  = out_valid_q;
	assign similarity = out_sim_q;
	assign zero_norm  = out_zero_q;
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// One digit of each integer square root per cycle.
	always_comb begin
		ta = ra_q + bit_q;
		tb = rb_q + bit_q;
		if (xa_q >= ta) begin
			xa_n = xa_q - ta;
			ra_n = (ra_q >> 1) + bit_q;
		end else begin
			xa_n = xa_q;
			ra_n = ra_q >> 1;
		end
		if (xb_q >= tb) begin
			xb_n = xb_q - tb;
			rb_n = (rb_q >> 1) + bit_q;
		end else begin
			xb_n = xb_q;
			rb_n = rb_q >> 1;
		end
	end

	always_comb begin
		mag    = dot_q[csu_pkg::SUM_W-1] ? (csu_pkg::SUM_W'(0) - dot_q) : dot_q;
		mag_sh = {mag, {csu_pkg::ROOT_SHIFT{1'b0}}};
		r_sh   = {r_q[csu_pkg::ROOT_IN_W-2:0], 1'b0};
		div_ge = r_q[csu_pkg::ROOT_IN_W-1] || (r_sh >= den_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (fifo_valid) state_q <= ST_SQRT;
				ST_SQRT: if (bit_q[0]) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_CHK;
				ST_CHK: begin
					if (den_q == '0 || mag_sh >= den_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == csu_pkg::DIV_CNT_W'(csu_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_SIGN;
					end
				end
				ST_SIGN: state_q <= ST_DONE;
				ST_DONE: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dot_q <= fifo_data.dot;
				xa_q  <= {fifo_data.norm_a, {csu_pkg::ROOT_SHIFT{1'b0}}};
				xb_q  <= {fifo_data.norm_b, {csu_pkg::ROOT_SHIFT{1'b0}}};
				ra_q  <= '0;
				rb_q  <= '0;
				bit_q <= BIT_INIT;
			end
			ST_SQRT: begin
				xa_q  <= xa_n;
				ra_q  <= ra_n;
				xb_q  <= xb_n;
				rb_q  <= rb_n;
				bit_q <= bit_q >> 2;
			end
			ST_MUL: begin
				den_q <= ra_q[csu_pkg::ROOT_W-1:0] * rb_q[csu_pkg::ROOT_W-1:0];
			end
			ST_CHK: begin
				neg_q  <= dot_q[csu_pkg::SUM_W-1];
				r_q    <= csu_pkg::ROOT_IN_W'(mag);
				quot_q <= '0;
				cnt_q  <= '0;
				if (den_q == '0) begin
					sim_q  <= '0;
					zero_q <= 1'b1;
				end else begin
					sim_q  <= dot_q[csu_pkg::SUM_W-1] ? csu_pkg::SIM_MIN : csu_pkg::SIM_MAX;
					zero_q <= 1'b0;
				end
			end
			ST_DIV: begin
				r_q    <= div_ge ? (r_sh - den_q) : r_sh;
				quot_q <= {quot_q[csu_pkg::QUOT_W-2:0], div_ge};
				cnt_q  <= cnt_q + 1'b1;
			end
			ST_SIGN: begin
				// quotient beyond the Q1.15 range saturates
				if (quot_q[csu_pkg::QUOT_W-1:csu_pkg::SIM_W-1] != '0) begin
					sim_q <= neg_q ? csu_pkg::SIM_MIN : csu_pkg::SIM_MAX;
				end else if (neg_q) begin
					sim_q <= csu_pkg::SIM_W'(0) - quot_q[csu_pkg::SIM_W-1:0];
				end else begin
					sim_q <= quot_q[csu_pkg::SIM_W-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sim_q  <= sim_q;
			out_zero_q <= zero_q;
		end
	end

endmodule
`default_nettype wire

// ----- design/cosine_similarity_unit.sv -----
// Cosine similarity unit: input pairs in, one Q1.15 similarity per vector out.
// Usage:
//   Input channel (in_valid/in_ready): one element pair a_elem/b_elem per
//   transfer, signed Q1.15, with last high on the final pair of a vector.
//   Output channel (out_valid/out_ready): one similarity per vector, Q1.15,
//   saturated; zero_norm is high (and similarity 0) when a norm is zero.
//   Throughput: one pair per cycle into the multiply-accumulate front end
//   while in_ready is high. The back end handles one vector at a time: 32
//   square-root steps for both norms in parallel, one multiply, then 31
//   divide steps unless a norm is zero or the result saturates. A two-entry
//   queue of finished sums sits in front of it, so short vectors stall the
//   input once both entries are taken.
//   Reset (arst_n low, asynchronous) clears the sums, empties the queue and
//   drops out_valid. A stalled receiver holds the result in the output
//   register; the back end waits at its end and the queue and front keep
//   filling until full, after which in_ready falls.
`default_nettype none
module cosine_similarity_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [csu_pkg::ELEM_W-1:0]  a_elem,
	input  wire logic signed [csu_pkg::ELEM_W-1:0]  b_elem,
	input  wire logic                               last,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [csu_pkg::SIM_W-1:0]        similarity,
	output logic                                    zero_norm
);

	logic               push_valid;
	logic               push_ready;
	csu_pkg::csu_sums_t push_data;
	logic               fifo_valid;
	logic               fifo_pop;
	csu_pkg::csu_sums_t fifo_data;

	csu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.a_elem     (a_elem),
		.b_elem     (b_elem),
		.last       (last),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	csu_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (fifo_valid),
		.pop_ready  (fifo_pop),
		.pop_data   (fifo_data)
	);

	csu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_valid (fifo_valid),
		.fifo_pop   (fifo_pop),
		.fifo_data  (fifo_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.similarity (similarity),
		.zero_norm  (zero_norm)
	);

`ifndef ASSERT_OFF
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_norm |-> similarity == '0)
		else $error("zero_norm result with nonzero similarity");

	a_full_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && !push_ready |-> !in_ready)
		else $error("input taken while queue full and final pair pending");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && push_ready |=> fifo_valid)
		else $error("queue empty right after a push");
`endif

endmodule
`default_nettype wire
